@@ rtl/d2q9c_pkg.sv @@
package d2q9c_pkg;

  localparam int POP_COUNT   = 9;
  localparam int FRAC        = 30;
  localparam int WEIGHT_BITS = 20;
  localparam int WORD_W      = 32;
  localparam int SUM_W       = 36;
  localparam int MOM_W       = 37;
  localparam int MAG_W       = 37;
  localparam int REM_W       = 32;
  localparam int DIV_STEPS   = 31;
  localparam int INT_SHIFT   = 31 - FRAC;
  localparam int SAT_W       = 72;
  localparam int DIRS_W      = 36;
  localparam int RELAX_W     = 31;
  localparam int CFG_W       = 60;
  localparam int IDX_W       = 3;
  // Queue depth must be a power of two; pointers wrap by overflow.
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [34:0] ONE_Q = 35'sd1 <<< FRAC;
  localparam logic [RELAX_W-1:0] RELAX_RESET = RELAX_W'(1) << FRAC;

  typedef enum logic [IDX_W-1:0] {
    REG_RELAX = 3'd0,
    REG_DIRS  = 3'd1,
    REG_WA    = 3'd2,
    REG_WB    = 3'd3,
    REG_WC    = 3'd4
  } cfg_reg_t;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [POP_COUNT-1:0][WORD_W-1:0] pops_t;

  typedef struct packed {
    word_t pop_0;
    word_t pop_1;
    word_t pop_2;
    word_t pop_3;
    word_t pop_4;
    word_t pop_5;
    word_t pop_6;
    word_t pop_7;
    word_t pop_8;
    logic  is_solid;
  } in_t;

  typedef struct packed {
    word_t post_0;
    word_t post_1;
    word_t post_2;
    word_t post_3;
    word_t post_4;
    word_t post_5;
    word_t post_6;
    word_t post_7;
    word_t post_8;
    word_t density;
    word_t vel_x;
    word_t vel_y;
  } out_t;

  // One classified cell as it crosses the queue.
  typedef struct packed {
    pops_t pop;
    logic  solid;
    word_t rho;
    word_t ux;
    word_t uy;
  } cell_t;

  typedef struct packed {
    logic [MAG_W-1:0]     mm;
    logic [REM_W-1:0]     rem;
    logic [DIV_STEPS-1:0] q;
    logic                 neg;
    logic                 ovf;
  } div_t;

  function automatic word_t sat32(input logic signed [SAT_W-1:0] v);
    word_t r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [1:0] dir_x(input logic [DIRS_W-1:0] dirs, input int k);
    return dirs[4*k +: 2];
  endfunction

  function automatic logic signed [1:0] dir_y(input logic [DIRS_W-1:0] dirs, input int k);
    return dirs[4*k+2 +: 2];
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [CFG_W-1:0] wa,
      input logic [CFG_W-1:0] wb, input logic [CFG_W-1:0] wc, input int k);
    logic [CFG_W-1:0] r;
    if (k < 3) begin
      r = wa;
    end else if (k < 6) begin
      r = wb;
    end else begin
      r = wc;
    end
    return r[WEIGHT_BITS*(k%3) +: WEIGHT_BITS];
  endfunction

  function automatic pops_t unpack_in(input in_t w);
    pops_t p;
    p[0] = w.pop_0;
    p[1] = w.pop_1;
    p[2] = w.pop_2;
    p[3] = w.pop_3;
    p[4] = w.pop_4;
    p[5] = w.pop_5;
    p[6] = w.pop_6;
    p[7] = w.pop_7;
    p[8] = w.pop_8;
    return p;
  endfunction

  function automatic out_t pack_out(input pops_t p, input word_t rho, input word_t ux,
      input word_t uy);
    out_t o;
    o.post_0  = p[0];
    o.post_1  = p[1];
    o.post_2  = p[2];
    o.post_3  = p[3];
    o.post_4  = p[4];
    o.post_5  = p[5];
    o.post_6  = p[6];
    o.post_7  = p[7];
    o.post_8  = p[8];
    o.density = rho;
    o.vel_x   = ux;
    o.vel_y   = uy;
    return o;
  endfunction

endpackage

@@ rtl/d2q9_bgk_cell_collision.sv @@
// D2Q9 BGK collision for one lattice cell per word.
// Input channel (in_valid / in_stall / in_word): nine signed Q2.30 populations
// and a solid flag. A word is taken on a rising edge with in_valid high and
// in_stall low. Output channel (out_valid / out_stall / out_word): the nine
// post-collision populations, the density and the two velocity components.
// Throughput is one cell per clock while the output is not stalled and the
// queue is not full. Both velocity components are formed in parallel by a
// 31-stage restoring divider, and the eight-stage equilibrium and relaxation
// pipeline lies behind it.
// The front part (moments and divider) feeds a four-word queue; the back part
// drains it. When the receiver raises out_stall the back pipeline holds, the
// queue fills, and only then is in_stall raised, so each side stalls on its own.
// Configuration writes (cfg_write, cfg_index, cfg_data) are registered and
// are meant to happen while the block is empty. Synchronous reset empties all
// pipelines and the queue and restores omega to one, directions and weights
// to zero.
module d2q9_bgk_cell_collision (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  d2q9c_pkg::in_t                     in_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output d2q9c_pkg::out_t                    out_word,
  input  logic                               cfg_write,
  input  logic [d2q9c_pkg::IDX_W-1:0]        cfg_index,
  input  logic [d2q9c_pkg::CFG_W-1:0]        cfg_data
);

  logic [d2q9c_pkg::RELAX_W-1:0] relax_rate;
  logic [d2q9c_pkg::DIRS_W-1:0]  lattice_dirs;
  logic [d2q9c_pkg::CFG_W-1:0]   weights_a;
  logic [d2q9c_pkg::CFG_W-1:0]   weights_b;
  logic [d2q9c_pkg::CFG_W-1:0]   weights_c;

  logic                          q_full;
  logic                          q_empty;
  logic                          q_push;
  logic                          q_pop;
  d2q9c_pkg::cell_t              q_wdata;
  d2q9c_pkg::cell_t              q_rdata;

  // Register file. Unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate   <= d2q9c_pkg::RELAX_RESET;
      lattice_dirs <= '0;
      weights_a    <= '0;
      weights_b    <= '0;
      weights_c    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        d2q9c_pkg::REG_RELAX: relax_rate   <= cfg_data[d2q9c_pkg::RELAX_W-1:0];
        d2q9c_pkg::REG_DIRS:  lattice_dirs <= cfg_data[d2q9c_pkg::DIRS_W-1:0];
        d2q9c_pkg::REG_WA:    weights_a    <= cfg_data;
        d2q9c_pkg::REG_WB:    weights_b    <= cfg_data;
        d2q9c_pkg::REG_WC:    weights_c    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front pipeline advances whenever the queue has room.
  assign in_stall = q_full;

  d2q9c_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (!q_full),
    .in_valid (in_valid),
    .in_word  (in_word),
    .dirs     (lattice_dirs),
    .push     (q_push),
    .item     (q_wdata)
  );

  d2q9c_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  d2q9c_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (q_rdata),
    .avail      (!q_empty),
    .pop        (q_pop),
    .relax_rate (relax_rate),
    .dirs       (lattice_dirs),
    .weights_a  (weights_a),
    .weights_b  (weights_b),
    .weights_c  (weights_c),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

`ifndef SYNTHESIS
  a_zero_density: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_word.density == '0) |->
      (out_word.vel_x == '0 && out_word.vel_y == '0))
    else $error("nonzero velocity reported for zero density");
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");
`endif

endmodule

@@ rtl/d2q9c_fifo.sv @@
module d2q9c_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  d2q9c_pkg::cell_t    wdata,
  output logic                full,
  input  logic                pop,
  output d2q9c_pkg::cell_t    rdata,
  output logic                empty
);

  d2q9c_pkg::cell_t                 mem [d2q9c_pkg::FIFO_DEPTH];
  logic [d2q9c_pkg::PTR_W-1:0]      wp;
  logic [d2q9c_pkg::PTR_W-1:0]      rp;
  logic [d2q9c_pkg::CNT_W-1:0]      cnt;

  assign full  = (cnt == d2q9c_pkg::CNT_W'(d2q9c_pkg::FIFO_DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

@@ rtl/d2q9c_front.sv @@
module d2q9c_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  d2q9c_pkg::in_t                     in_word,
  input  logic [d2q9c_pkg::DIRS_W-1:0]       dirs,
  output logic                               push,
  output d2q9c_pkg::cell_t                   item
);

  localparam int NST = d2q9c_pkg::DIV_STEPS + 2;

  typedef struct packed {
    d2q9c_pkg::pops_t        pop;
    logic                    solid;
    d2q9c_pkg::word_t        rho;
    logic [31:0]             rm;
    logic                    zero;
    d2q9c_pkg::div_t         dx;
    d2q9c_pkg::div_t         dy;
  } fr_t;

  function automatic d2q9c_pkg::div_t div_step(input d2q9c_pkg::div_t d,
      input logic [d2q9c_pkg::REM_W-1:0] rm, input int i);
    d2q9c_pkg::div_t             r;
    logic [d2q9c_pkg::REM_W:0]   t;
    logic                        b;
    r = d;
    b = 1'b0;
    if (i >= d2q9c_pkg::FRAC) begin
      b = d.mm[i-d2q9c_pkg::FRAC];
    end
    t = {d.rem, b};
    if (t >= {1'b0, rm}) begin
      r.rem  = d2q9c_pkg::REM_W'(t - {1'b0, rm});
      r.q[i] = 1'b1;
    end else begin
      r.rem  = t[d2q9c_pkg::REM_W-1:0];
      r.q[i] = 1'b0;
    end
    return r;
  endfunction

  function automatic fr_t fr_step(input fr_t s, input int i);
    fr_t r;
    r    = s;
    r.dx = div_step(s.dx, s.rm, i);
    r.dy = div_step(s.dy, s.rm, i);
    return r;
  endfunction

  function automatic d2q9c_pkg::div_t div_init(input d2q9c_pkg::div_t d,
      input logic [31:0] rm);
    d2q9c_pkg::div_t r;
    r     = d;
    r.ovf = (64'(d.mm) >= (64'(rm) << d2q9c_pkg::INT_SHIFT));
    r.rem = d2q9c_pkg::REM_W'(d.mm >> d2q9c_pkg::INT_SHIFT);
    r.q   = '0;
    return r;
  endfunction

  function automatic d2q9c_pkg::word_t div_result(input d2q9c_pkg::div_t d,
      input logic zero);
    d2q9c_pkg::word_t r;
    if (zero) begin
      r = '0;
    end else if (d.ovf) begin
      r = d.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (d.neg) begin
      r = -$signed({1'b0, d.q});
    end else begin
      r = $signed({1'b0, d.q});
    end
    return r;
  endfunction

  logic                                       v0;
  logic                                       v1;
  d2q9c_pkg::pops_t                           pop0;
  d2q9c_pkg::pops_t                           pop1;
  logic                                       solid0;
  logic                                       solid1;
  logic signed [d2q9c_pkg::SUM_W-1:0]         sum1;
  logic signed [d2q9c_pkg::MOM_W-1:0]         mx1;
  logic signed [d2q9c_pkg::MOM_W-1:0]         my1;
  logic signed [d2q9c_pkg::SUM_W-1:0]         sum_c;
  logic signed [d2q9c_pkg::MOM_W-1:0]         mx_c;
  logic signed [d2q9c_pkg::MOM_W-1:0]         my_c;
  fr_t                                        s2_c;
  fr_t                                        init_c;
  fr_t                                        st [NST];
  logic [NST-1:0]                             sv;

  // Zeroth and first moments over the nine directions.
  always_comb begin
    sum_c = '0;
    mx_c  = '0;
    my_c  = '0;
    for (int k = 0; k < d2q9c_pkg::POP_COUNT; k++) begin
      sum_c = sum_c + d2q9c_pkg::SUM_W'($signed(pop0[k]));
      mx_c  = mx_c + d2q9c_pkg::MOM_W'(d2q9c_pkg::dir_x(dirs, k))
                   * d2q9c_pkg::MOM_W'($signed(pop0[k]));
      my_c  = my_c + d2q9c_pkg::MOM_W'(d2q9c_pkg::dir_y(dirs, k))
                   * d2q9c_pkg::MOM_W'($signed(pop0[k]));
    end
  end

  // Saturate density and split the momenta into sign and magnitude.
  always_comb begin
    s2_c          = '0;
    s2_c.pop      = pop1;
    s2_c.solid    = solid1;
    s2_c.rho      = d2q9c_pkg::sat32(d2q9c_pkg::SAT_W'(sum1));
    s2_c.rm       = s2_c.rho[31] ? (~s2_c.rho + 32'd1) : s2_c.rho;
    s2_c.zero     = (s2_c.rho == '0);
    s2_c.dx.neg   = mx1[d2q9c_pkg::MOM_W-1] != s2_c.rho[31];
    s2_c.dy.neg   = my1[d2q9c_pkg::MOM_W-1] != s2_c.rho[31];
    s2_c.dx.mm    = mx1[d2q9c_pkg::MOM_W-1] ? d2q9c_pkg::MAG_W'(-mx1)
                                            : d2q9c_pkg::MAG_W'(mx1);
    s2_c.dy.mm    = my1[d2q9c_pkg::MOM_W-1] ? d2q9c_pkg::MAG_W'(-my1)
                                            : d2q9c_pkg::MAG_W'(my1);
  end

  always_comb begin
    init_c    = st[0];
    init_c.dx = div_init(st[0].dx, st[0].rm);
    init_c.dy = div_init(st[0].dy, st[0].rm);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pop0   <= d2q9c_pkg::unpack_in(in_word);
      solid0 <= in_word.is_solid;
      pop1   <= pop0;
      solid1 <= solid0;
      sum1   <= sum_c;
      mx1    <= mx_c;
      my1    <= my_c;
      st[0]  <= s2_c;
      st[1]  <= init_c;
      for (int j = 0; j < d2q9c_pkg::DIV_STEPS; j++) begin
        st[j+2] <= fr_step(st[j+1], d2q9c_pkg::DIV_STEPS - 1 - j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      sv <= '0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      sv <= {sv[NST-2:0], v1};
    end
  end

  assign push       = sv[NST-1] && en;
  assign item.pop   = st[NST-1].pop;
  assign item.solid = st[NST-1].solid;
  assign item.rho   = st[NST-1].rho;
  assign item.ux    = div_result(st[NST-1].dx, st[NST-1].zero);
  assign item.uy    = div_result(st[NST-1].dy, st[NST-1].zero);

endmodule

@@ rtl/d2q9c_back.sv @@
module d2q9c_back (
  input  logic                                clk,
  input  logic                                rst,
  input  d2q9c_pkg::cell_t                    item,
  input  logic                                avail,
  output logic                                pop,
  input  logic [d2q9c_pkg::RELAX_W-1:0]       relax_rate,
  input  logic [d2q9c_pkg::DIRS_W-1:0]        dirs,
  input  logic [d2q9c_pkg::CFG_W-1:0]         weights_a,
  input  logic [d2q9c_pkg::CFG_W-1:0]         weights_b,
  input  logic [d2q9c_pkg::CFG_W-1:0]         weights_c,
  output logic                                out_valid,
  input  logic                                out_stall,
  output d2q9c_pkg::out_t                     out_word
);

  localparam int N = d2q9c_pkg::POP_COUNT;
  localparam int F = d2q9c_pkg::FRAC;

  logic                    en;
  logic [6:0]              v;
  d2q9c_pkg::cell_t        c1, c2, c3, c4, c5, c6, c7;
  logic signed [63:0]      sqx1, sqy1;
  d2q9c_pkg::word_t        usq2, usqr3;
  d2q9c_pkg::word_t        cu1 [N];
  d2q9c_pkg::word_t        cu2 [N];
  d2q9c_pkg::word_t        cu3 [N];
  logic signed [52:0]      rwp1 [N];
  d2q9c_pkg::word_t        rw2 [N];
  d2q9c_pkg::word_t        rw3 [N];
  d2q9c_pkg::word_t        rw4 [N];
  logic signed [63:0]      cusq2 [N];
  d2q9c_pkg::word_t        half3 [N];
  d2q9c_pkg::word_t        poly4 [N];
  logic signed [63:0]      fp5 [N];
  logic signed [32:0]      d6 [N];
  logic signed [64:0]      dp7 [N];

  d2q9c_pkg::word_t        cu_c [N];
  logic signed [52:0]      rwp_c [N];
  d2q9c_pkg::pops_t        post_c;

  assign en  = !out_valid || !out_stall;
  assign pop = en && avail;

  // Lane terms that need only the velocity and density.
  always_comb begin
    logic signed [34:0] dot;
    for (int k = 0; k < N; k++) begin
      dot = 35'(d2q9c_pkg::dir_x(dirs, k)) * 35'(item.ux)
          + 35'(d2q9c_pkg::dir_y(dirs, k)) * 35'(item.uy);
      cu_c[k]  = d2q9c_pkg::sat32(d2q9c_pkg::SAT_W'(37'(dot) * 37'sd3));
      rwp_c[k] = 53'(item.rho) * $signed(53'(d2q9c_pkg::weight_of(weights_a, weights_b,
                 weights_c, k)));
    end
  end

  // Final relaxation or bounce-back.
  always_comb begin
    logic signed [36:0] r;
    for (int k = 0; k < N; k++) begin
      r = 37'($signed(c7.pop[k])) - 37'(dp7[k] >>> F);
      post_c[k] = c7.solid ? c7.pop[N-1-k] : d2q9c_pkg::sat32(d2q9c_pkg::SAT_W'(r));
    end
  end

  always_ff @(posedge clk) begin
    logic signed [34:0] p;
    logic signed [64:0] usum;
    d2q9c_pkg::word_t   feq;
    if (en) begin
      c1   <= item;
      sqx1 <= 64'(item.ux) * 64'(item.ux);
      sqy1 <= 64'(item.uy) * 64'(item.uy);
      c2   <= c1;
      usum  = $signed({1'b0, $unsigned(sqx1)}) + $signed({1'b0, $unsigned(sqy1)});
      usq2 <= d2q9c_pkg::sat32(d2q9c_pkg::SAT_W'(usum >>> F));
      c3    <= c2;
      usqr3 <= d2q9c_pkg::sat32(d2q9c_pkg::SAT_W'((34'(usq2) * 34'sd3) >>> 1));
      c4 <= c3;
      c5 <= c4;
      c6 <= c5;
      c7 <= c6;
      for (int k = 0; k < N; k++) begin
        cu1[k]   <= cu_c[k];
        rwp1[k]  <= rwp_c[k];
        cu2[k]   <= cu1[k];
        cusq2[k] <= 64'(cu1[k]) * 64'(cu1[k]);
        rw2[k]   <= d2q9c_pkg::sat32(d2q9c_pkg::SAT_W'(rwp1[k] >>> d2q9c_pkg::WEIGHT_BITS));
        cu3[k]   <= cu2[k];
        rw3[k]   <= rw2[k];
        half3[k] <= d2q9c_pkg::sat32($signed(d2q9c_pkg::SAT_W'($unsigned(cusq2[k]) >> (F+1))));
        p         = d2q9c_pkg::ONE_Q + 35'(cu3[k]) + 35'(half3[k]) - 35'(usqr3);
        poly4[k] <= d2q9c_pkg::sat32(d2q9c_pkg::SAT_W'(p));
        rw4[k]   <= rw3[k];
        fp5[k]   <= 64'(rw4[k]) * 64'(poly4[k]);
        feq       = d2q9c_pkg::sat32(d2q9c_pkg::SAT_W'(fp5[k] >>> F));
        d6[k]    <= 33'($signed(c5.pop[k])) - 33'(feq);
        dp7[k]   <= 65'(d6[k]) * $signed(65'(relax_rate));
      end
      out_word <= d2q9c_pkg::pack_out(post_c, c7.rho, c7.ux, c7.uy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[5:0], avail};
      out_valid <= v[6];
    end
  end

endmodule
